>>> rtl/core/ndd_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the Newton divided-difference interpolator.
// No dependencies; used by every module of the block.
package ndd_pkg;

    localparam int DATA_W    = 32;
    localparam int MUL_SPLIT = 16;

    localparam logic       ACT_LOAD   = 1'b0;
    localparam logic       ACT_EVAL   = 1'b1;
    localparam logic       KIND_EVAL  = 1'b0;
    localparam logic       KIND_BUILD = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    // Result of an arithmetic unit: clamped value and its saturation flag.
    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } t_res;

endpackage

>>> rtl/core/newton_divided_difference_interp.sv
`timescale 1ns / 1ps
// Newton divided-difference interpolator in signed fixed point. A load that
// is not the last node stores the node and returns no result. Loading node n
// (the order) runs a duplicate check over every node pair, then n(n+1)/2
// divisions on the bit-serial divider, and returns a status. An evaluate runs
// Horner steps; each waits on a memory read and the four-stage multiply-add.
// The input stalls while an item is in progress; the finished result sits in
// an output register.
// Depends on ndd_pkg, ndd_store, ndd_div and ndd_mac.
module newton_divided_difference_interp #(
    parameter int MAX_ORDER = 15,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [3:0]  i_node_index,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic signed [31:0] o_value,
    output logic [1:0]  o_status
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DUP_RD   = 11'b00000000010,
        S_DUP_CMP  = 11'b00000000100,
        S_DIV_RD   = 11'b00000001000,
        S_DIV_GO   = 11'b00000010000,
        S_DIV_WAIT = 11'b00000100000,
        S_EV_INIT  = 11'b00001000000,
        S_EV_ACC0  = 11'b00010000000,
        S_EV_RD    = 11'b00100000000,
        S_EV_GO    = 11'b01000000000,
        S_EV_WAIT  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic   r_emit;

    logic [3:0]    r_order;
    logic          r_ready;
    logic [AW-1:0] r_n;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_k;
    logic signed [31:0] r_xq;
    logic signed [31:0] r_acc;
    logic          r_sat;
    logic          r_res_kind;
    logic [31:0]   r_res_val;
    logic [1:0]    r_res_stat;

    logic [AW-1:0] eff_n;
    logic [AW-1:0] ld_addr;
    logic          in_acc;
    logic          ld_ok;
    logic          wc_en;
    logic [AW-1:0] waddr;
    logic [31:0]   wc_data;
    logic [AW-1:0] x_ra;
    logic [AW-1:0] x_rb;
    logic [31:0]   xa;
    logic [31:0]   xb;
    logic [31:0]   ca;
    logic [31:0]   cb;
    logic          div_start;
    logic          div_done;
    ndd_pkg::t_res div_res;
    logic          mac_start;
    logic          mac_done;
    ndd_pkg::t_res mac_res;
    logic          emit_go;

    always_comb begin
        if (r_order == '0) begin
            eff_n = AW'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            eff_n = AW'(MAX_ORDER);
        end else begin
            eff_n = AW'(r_order);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_emit;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign ld_addr     = AW'(i_node_index);
    assign ld_ok       = in_acc && (i_action == ndd_pkg::ACT_LOAD)
                         && (int'(i_node_index) <= MAX_ORDER);
    assign emit_go     = r_emit && (!o_out_valid || !i_out_stall);

    assign wc_en   = ld_ok || ((r_state == S_DIV_WAIT) && div_done);
    assign waddr   = ld_ok ? ld_addr : r_k;
    assign wc_data = ld_ok ? i_y_value : div_res.value;
    assign x_ra    = (r_state == S_DUP_RD) ? r_j : r_k;
    assign x_rb    = (r_state == S_DUP_RD) ? r_k : r_k - r_i;

    assign div_start = (r_state == S_DIV_GO);
    assign mac_start = (r_state == S_EV_GO);

    ndd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wx_en (ld_ok),
        .i_wc_en (wc_en),
        .i_waddr (waddr),
        .i_wx    (i_x_value),
        .i_wc    (wc_data),
        .i_x_ra  (x_ra),
        .i_x_rb  (x_rb),
        .i_c_ra  (r_k),
        .i_c_rb  (r_k - AW'(1)),
        .o_xa    (xa),
        .o_xb    (xb),
        .o_ca    (ca),
        .o_cb    (cb)
    );

    ndd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (33'($signed(ca)) - 33'($signed(cb))),
        .i_den   (33'($signed(xa)) - 33'($signed(xb))),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    ndd_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_xq    (r_xq),
        .i_nx    ($signed(xa)),
        .i_acc   (r_acc),
        .i_cf    ($signed(ca)),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit      <= 1'b0;
            r_order     <= 4'd1;
            r_ready     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (emit_go) begin
                r_emit      <= 1'b0;
                o_out_valid <= 1'b1;
                o_kind      <= r_res_kind;
                o_value     <= r_res_val;
                o_status    <= r_res_stat;
            end
            if (i_cfg_valid) begin
                r_order <= i_cfg_data;
                r_ready <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (ld_ok) begin
                        r_ready <= 1'b0;
                        if (ld_addr == eff_n) begin
                            r_n     <= eff_n;
                            r_k     <= AW'(1);
                            r_j     <= '0;
                            r_sat   <= 1'b0;
                            r_state <= S_DUP_RD;
                        end
                    end else if (in_acc && i_action == ndd_pkg::ACT_EVAL && r_ready) begin
                        r_n     <= eff_n;
                        r_k     <= eff_n;
                        r_xq    <= i_x_value;
                        r_sat   <= 1'b0;
                        r_state <= S_EV_INIT;
                    end
                end
                S_DUP_RD: begin
                    r_state <= S_DUP_CMP;
                end
                S_DUP_CMP: begin
                    if (xa == xb) begin
                        r_res_kind <= ndd_pkg::KIND_BUILD;
                        r_res_val  <= '0;
                        r_res_stat <= ndd_pkg::ST_DUP;
                        r_emit     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else if (r_j + AW'(1) < r_k) begin
                        r_j     <= r_j + AW'(1);
                        r_state <= S_DUP_RD;
                    end else if (r_k == r_n) begin
                        r_i     <= AW'(1);
                        r_k     <= r_n;
                        r_state <= S_DIV_RD;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_j     <= '0;
                        r_state <= S_DUP_RD;
                    end
                end
                S_DIV_RD: begin
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_sat <= r_sat | div_res.sat;
                        if (r_k > r_i) begin
                            r_k     <= r_k - AW'(1);
                            r_state <= S_DIV_RD;
                        end else if (r_i == r_n) begin
                            r_ready    <= 1'b1;
                            r_res_kind <= ndd_pkg::KIND_BUILD;
                            r_res_val  <= '0;
                            r_res_stat <= (r_sat | div_res.sat) ? ndd_pkg::ST_SAT
                                                                : ndd_pkg::ST_OK;
                            r_emit     <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_i     <= r_i + AW'(1);
                            r_k     <= r_n;
                            r_state <= S_DIV_RD;
                        end
                    end
                end
                S_EV_INIT: begin
                    r_state <= S_EV_ACC0;
                end
                S_EV_ACC0: begin
                    r_acc   <= $signed(ca);
                    r_k     <= r_k - AW'(1);
                    r_state <= S_EV_RD;
                end
                S_EV_RD: begin
                    r_state <= S_EV_GO;
                end
                S_EV_GO: begin
                    r_state <= S_EV_WAIT;
                end
                S_EV_WAIT: begin
                    if (mac_done) begin
                        r_acc <= $signed(mac_res.value);
                        r_sat <= r_sat | mac_res.sat;
                        if (r_k == '0) begin
                            r_res_kind <= ndd_pkg::KIND_EVAL;
                            r_res_val  <= mac_res.value;
                            r_res_stat <= (r_sat | mac_res.sat) ? ndd_pkg::ST_SAT
                                                                : ndd_pkg::ST_OK;
                            r_emit     <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_k     <= r_k - AW'(1);
                            r_state <= S_EV_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ndd_store.sv
`timescale 1ns / 1ps
// Node store: abscissa and coefficient memories, one write port and two
// registered read ports each. Depends on ndd_pkg.
module ndd_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_wx_en,
    input  logic                      i_wc_en,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ndd_pkg::DATA_W-1:0] i_wx,
    input  logic [ndd_pkg::DATA_W-1:0] i_wc,
    input  logic [AW-1:0]             i_x_ra,
    input  logic [AW-1:0]             i_x_rb,
    input  logic [AW-1:0]             i_c_ra,
    input  logic [AW-1:0]             i_c_rb,
    output logic [ndd_pkg::DATA_W-1:0] o_xa,
    output logic [ndd_pkg::DATA_W-1:0] o_xb,
    output logic [ndd_pkg::DATA_W-1:0] o_ca,
    output logic [ndd_pkg::DATA_W-1:0] o_cb
);

    logic [ndd_pkg::DATA_W-1:0] mem_x [DEPTH];
    logic [ndd_pkg::DATA_W-1:0] mem_c [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wx_en) begin
            mem_x[i_waddr] <= i_wx;
        end
        if (i_wc_en) begin
            mem_c[i_waddr] <= i_wc;
        end
        o_xa <= mem_x[i_x_ra];
        o_xb <= mem_x[i_x_rb];
        o_ca <= mem_c[i_c_ra];
        o_cb <= mem_c[i_c_rb];
    end

endmodule

>>> rtl/core/ndd_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for one divided difference, truncating toward
// zero and clamping to 32 bits. Depends on ndd_pkg.
module ndd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [32:0]   i_num,
    input  logic signed [32:0]   i_den,
    output logic                 o_done,
    output ndd_pkg::t_res        o_res
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [33:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [32:0]   r_den;
    logic          r_neg;

    logic [32:0] num_mag;
    logic [32:0] den_mag;
    logic [33:0] rem_sh;
    logic        ge;
    logic        fits;

    assign num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign rem_sh  = {r_rem[32:0], r_quo[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};

    // A negative quotient may reach 2^31; a positive one only 2^31 - 1.
    always_comb begin
        if (r_neg) begin
            fits = (r_quo[NW-1:32] == '0) && (!r_quo[31] || (r_quo[30:0] == '0));
        end else begin
            fits = (r_quo[NW-1:31] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_quo  <= {num_mag, {FRAC_BITS{1'b0}}};
                r_den  <= den_mag;
                r_neg  <= i_num[32] ^ i_den[32];
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_quo <= {r_quo[NW-2:0], ge};
                end else begin
                    r_busy  <= 1'b0;
                    o_done  <= 1'b1;
                    o_res.sat <= !fits;
                    if (!fits) begin
                        o_res.value <= r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
                    end else begin
                        o_res.value <= r_neg ? 32'(~r_quo + 1'b1) : r_quo[31:0];
                    end
                end
            end
        end
    end

endmodule

>>> rtl/core/ndd_mac.sv
`timescale 1ns / 1ps
// One Horner step: cf + trunc((xq - nx) * acc / 2^FRAC_BITS), clamped.
// Four-stage pipeline with the product split in two halves. Depends on ndd_pkg.
module ndd_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_xq,
    input  logic signed [31:0]   i_nx,
    input  logic signed [31:0]   i_acc,
    input  logic signed [31:0]   i_cf,
    output logic                 o_done,
    output ndd_pkg::t_res        o_res
);

    localparam int PW = 66;
    localparam int HW = 33 - ndd_pkg::MUL_SPLIT;

    logic [2:0] r_vld;

    logic signed [32:0]   r_d;
    logic signed [31:0]   r_acc;
    logic signed [31:0]   r_cf1;
    logic signed [31:0]   r_cf2;
    logic signed [31:0]   r_cf3;
    logic signed [HW-1:0] r_dh;
    logic signed [31:0]   r_acc2;
    logic signed [48:0]   r_plo;
    logic signed [PW-1:0] r_prod;

    logic signed [48:0]   p_lo;
    logic signed [48:0]   p_hi;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] shifted;
    logic signed [PW:0]   sum;

    assign p_lo = $signed({1'b0, r_d[ndd_pkg::MUL_SPLIT-1:0]}) * r_acc;
    assign p_hi = r_dh * r_acc2;
    assign prod = (PW'(p_hi) <<< ndd_pkg::MUL_SPLIT) + PW'(r_plo);

    // Bias negative products so the arithmetic shift truncates toward zero.
    assign bias    = r_prod[PW-1] ? ((PW'(1) <<< FRAC_BITS) - PW'(1)) : '0;
    assign shifted = (r_prod + bias) >>> FRAC_BITS;
    assign sum     = (PW+1)'(shifted) + (PW+1)'(r_cf3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_start};
            o_done <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= 33'(i_xq) - 33'(i_nx);
        r_acc  <= i_acc;
        r_cf1  <= i_cf;
        r_plo  <= p_lo;
        r_dh   <= r_d[32:ndd_pkg::MUL_SPLIT];
        r_acc2 <= r_acc;
        r_cf2  <= r_cf1;
        r_prod <= prod;
        r_cf3  <= r_cf2;
        if (sum[PW:31] == '0 || sum[PW:31] == '1) begin
            o_res.sat   <= 1'b0;
            o_res.value <= sum[31:0];
        end else begin
            o_res.sat   <= 1'b1;
            o_res.value <= sum[PW] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
    end

endmodule

>>> rtl/core/ndd_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the interpolator's result channel, bound to the top
// level. Depends on ndd_pkg.
module ndd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [3:0]  i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_action,
    input logic [3:0]  i_node_index,
    input logic [31:0] i_x_value,
    input logic [31:0] i_y_value,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [31:0] o_value,
    input logic [1:0]  o_status
);

    // A stalled result must stay put until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_kind) && $stable(o_status))
        else $error("stalled result changed");

    a_build_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == ndd_pkg::KIND_BUILD |-> o_value == '0)
        else $error("build status carries a nonzero value");

    a_eval_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == ndd_pkg::KIND_EVAL |-> o_status != ndd_pkg::ST_DUP)
        else $error("evaluation reports duplicate nodes");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ndd_pkg::ST_OK || o_status == ndd_pkg::ST_DUP
            || o_status == ndd_pkg::ST_SAT)
        else $error("undefined status code");

endmodule

bind newton_divided_difference_interp ndd_checker u_ndd_checker (.*);
